[src/jdr_pkg.sv]
// ============================================================================
// jdr_pkg
// Shared types and constants for the joystick direction, auto-repeat and
// button debounce block.
// ============================================================================
package jdr_pkg;

    // Default number of samples averaged into the centre
    localparam int CAL_SAMPLES_DEF = 32;

    // Field widths
    localparam int AXIS_W  = 16;
    localparam int TICK_W  = 32;
    localparam int CFG16_W = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADZONE       = 3'd0,
        CFG_THRESHOLD      = 3'd1,
        CFG_INVERT_Y       = 3'd2,
        CFG_REPEAT_INITIAL = 3'd3,
        CFG_REPEAT_PERIOD  = 3'd4,
        CFG_DEBOUNCE       = 3'd5
    } cfg_idx_t;

    // Configuration reset values
    localparam logic [CFG16_W-1:0] DEADZONE_RST       = 16'd4000;
    localparam logic [CFG16_W-1:0] THRESHOLD_RST      = 16'd12000;
    localparam logic               INVERT_Y_RST       = 1'b0;
    localparam logic [CFG16_W-1:0] REPEAT_INITIAL_RST = 16'd300;
    localparam logic [CFG16_W-1:0] REPEAT_PERIOD_RST  = 16'd120;
    localparam logic [CFG16_W-1:0] DEBOUNCE_RST       = 16'd30;

    // Direction codes
    typedef enum logic [2:0] {
        DIR_NEUTRAL = 3'd0,
        DIR_UP      = 3'd1,
        DIR_DOWN    = 3'd2,
        DIR_LEFT    = 3'd3,
        DIR_RIGHT   = 3'd4
    } dir_t;

    // One joystick sample
    typedef struct packed {
        logic [AXIS_W-1:0] x_sample;
        logic [AXIS_W-1:0] y_sample;
        logic              button_pressed;
        logic [TICK_W-1:0] tick_now;
    } jdr_in_t;

    // One result
    typedef struct packed {
        logic [2:0] direction_event;
        logic       select_event;
        logic       calibrating;
    } jdr_out_t;

endpackage

[src/joystick_direction_repeat_debounce.sv]
// ============================================================================
// joystick_direction_repeat_debounce
// Joystick sample decoder: centre calibration, deadzone, direction
// classification with auto-repeat, and debounced select button.
// ============================================================================
// Usage:
//   in_valid/in_ready/in_data carry one joystick sample per request;
//   out_valid/out_ready/out_data return exactly one result per request, in
//   order. cfg_valid/cfg_ready/cfg_index/cfg_data write the six settings
//   (cfg_ready is always high); write them only while the block is idle.
//   A request passes the input register, then the decode logic into the
//   result register. Throughput is one sample per cycle while the receiver
//   does not stall, set by the single decode stage.
//   The first CAL_SAMPLES samples after reset are summed as they are taken;
//   their averages become the centre (a registered reciprocal multiply of
//   the sums) and those results carry calibrating = 1 with no events.
//   Reset restores the default settings, clears calibration, the held
//   direction, the repeat deadline and the debounced button state.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_ready drops only when both are occupied.
// ============================================================================
module joystick_direction_repeat_debounce #(
    parameter int CAL_SAMPLES = jdr_pkg::CAL_SAMPLES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  jdr_pkg::jdr_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output jdr_pkg::jdr_out_t                   out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jdr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [jdr_pkg::CFG16_W-1:0]         cfg_data
);
    import jdr_pkg::*;

    // Calibration sizing and reciprocal for the centre average
    localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
    localparam int LOG_C   = $clog2(CAL_SAMPLES);
    localparam int SUM_W   = AXIS_W + LOG_C;
    localparam int SHIFT   = SUM_W + LOG_C;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [CNT_W-1:0]   CAL_DONE = CNT_W'(CAL_SAMPLES);

    // Magnitude of a 17-bit signed offset
    function automatic logic [AXIS_W-1:0] mag17(input logic signed [AXIS_W:0] v);
        logic signed [AXIS_W:0] neg;
        neg = -v;
        return v[AXIS_W] ? neg[AXIS_W-1:0] : v[AXIS_W-1:0];
    endfunction

    // Settings
    logic [CFG16_W-1:0] deadzone_reg, threshold_reg;
    logic               invert_y_reg;
    logic [CFG16_W-1:0] rep_init_reg, rep_period_reg, debounce_reg;

    // Calibration state
    logic [CNT_W-1:0]   calib_cnt_reg;
    logic [SUM_W-1:0]   sum_x_reg, sum_y_reg;
    logic [AXIS_W-1:0]  center_x_reg, center_y_reg;
    logic [PROD_W-1:0]  prod_x, prod_y;

    // Decode state
    dir_t               prev_dir_reg, prev_dir_next;
    logic [TICK_W-1:0]  deadline_reg, deadline_next;
    logic               press_reg, press_next;
    logic [TICK_W-1:0]  last_chg_reg, last_chg_next;

    // Pipeline registers
    logic               in_valid_reg;
    jdr_in_t            in_data_reg;
    logic               in_cal_reg;
    logic               out_valid_reg;
    jdr_out_t           out_data_reg, out_data_next;

    logic               in_accept, advance, cal_phase;

    // Handshake
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cal_phase = (calib_cnt_reg != CAL_DONE);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg   <= DEADZONE_RST;
            threshold_reg  <= THRESHOLD_RST;
            invert_y_reg   <= INVERT_Y_RST;
            rep_init_reg   <= REPEAT_INITIAL_RST;
            rep_period_reg <= REPEAT_PERIOD_RST;
            debounce_reg   <= DEBOUNCE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DEADZONE:       deadzone_reg   <= cfg_data;
                CFG_THRESHOLD:      threshold_reg  <= cfg_data;
                CFG_INVERT_Y:       invert_y_reg   <= cfg_data[0];
                CFG_REPEAT_INITIAL: rep_init_reg   <= cfg_data;
                CFG_REPEAT_PERIOD:  rep_period_reg <= cfg_data;
                CFG_DEBOUNCE:       debounce_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Calibration sums, taken as each request is accepted during calibration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_cnt_reg <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
        end
        else if (in_accept && cal_phase)
        begin
            calib_cnt_reg <= calib_cnt_reg + CNT_W'(1);
            sum_x_reg     <= sum_x_reg + SUM_W'(in_data.x_sample);
            sum_y_reg     <= sum_y_reg + SUM_W'(in_data.y_sample);
        end
    end

    // Centre = floor(sum / CAL_SAMPLES) by reciprocal multiply; sums freeze
    // once calibration ends, so the centre settles in the cycle after that
    assign prod_x = PROD_W'(sum_x_reg) * PROD_W'(RECIP);
    assign prod_y = PROD_W'(sum_y_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        center_x_reg <= prod_x[SHIFT +: AXIS_W];
        center_y_reg <= prod_y[SHIFT +: AXIS_W];
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_data_reg <= in_data;
            in_cal_reg  <= cal_phase;
        end
    end

    // Direction classification
    logic signed [AXIS_W:0]   dx, dy_raw, dy, dxz, dyz;
    logic [AXIS_W-1:0]        mag_x, mag_y;
    logic signed [AXIS_W+1:0] dx_w, dy_w, th_pos, th_neg;
    dir_t                     dir;

    always_comb
    begin
        dx     = $signed({1'b0, in_data_reg.x_sample}) - $signed({1'b0, center_x_reg});
        dy_raw = $signed({1'b0, in_data_reg.y_sample}) - $signed({1'b0, center_y_reg});
        dy     = invert_y_reg ? -dy_raw : dy_raw;
        dxz    = (mag17(dx) < deadzone_reg) ? '0 : dx;
        dyz    = (mag17(dy) < deadzone_reg) ? '0 : dy;
        mag_x  = mag17(dxz);
        mag_y  = mag17(dyz);
        dx_w   = {dxz[AXIS_W], dxz};
        dy_w   = {dyz[AXIS_W], dyz};
        th_pos = $signed({2'b00, threshold_reg});
        th_neg = -th_pos;
        dir    = DIR_NEUTRAL;
        if (dxz == '0 && dyz == '0)
            dir = DIR_NEUTRAL;
        else if (mag_x >= mag_y)
        begin
            if (dx_w > th_pos)
                dir = DIR_RIGHT;
            else if (dx_w < th_neg)
                dir = DIR_LEFT;
        end
        else
        begin
            if (dy_w > th_pos)
                dir = DIR_UP;
            else if (dy_w < th_neg)
                dir = DIR_DOWN;
        end
    end

    // Repeat and debounce decisions, result assembly
    logic [TICK_W-1:0] now, elapsed;

    always_comb
    begin
        now           = in_data_reg.tick_now;
        elapsed       = now - last_chg_reg;
        prev_dir_next = prev_dir_reg;
        deadline_next = deadline_reg;
        press_next    = press_reg;
        last_chg_next = last_chg_reg;
        out_data_next = '0;
        if (in_cal_reg)
            out_data_next.calibrating = 1'b1;
        else
        begin
            // direction change or held repeat
            if (dir != prev_dir_reg)
            begin
                prev_dir_next = dir;
                if (dir != DIR_NEUTRAL)
                begin
                    out_data_next.direction_event = dir;
                    deadline_next = now + TICK_W'(rep_init_reg);
                end
            end
            else if (dir != DIR_NEUTRAL && now >= deadline_reg)
            begin
                out_data_next.direction_event = dir;
                deadline_next = now + TICK_W'(rep_period_reg);
            end
            // debounced button
            if (in_data_reg.button_pressed != press_reg
                && elapsed >= TICK_W'(debounce_reg))
            begin
                press_next    = in_data_reg.button_pressed;
                last_chg_next = now;
                out_data_next.select_event = in_data_reg.button_pressed;
            end
        end
    end

    // Decode state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_dir_reg  <= DIR_NEUTRAL;
            deadline_reg  <= '0;
            press_reg     <= 1'b0;
            last_chg_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                prev_dir_reg <= prev_dir_next;
                deadline_reg <= deadline_next;
                press_reg    <= press_next;
                last_chg_reg <= last_chg_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= out_data_next;
    end

endmodule

[src/jdr_chk.sv]
// ============================================================================
// jdr_chk
// Port-level checks for the joystick decoder, bound to the top level.
// ============================================================================
module jdr_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input jdr_pkg::jdr_out_t out_data
);
    import jdr_pkg::*;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Only defined direction codes come out
    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.direction_event == DIR_NEUTRAL
                    || out_data.direction_event == DIR_UP
                    || out_data.direction_event == DIR_DOWN
                    || out_data.direction_event == DIR_LEFT
                    || out_data.direction_event == DIR_RIGHT))
        else $error("undefined direction code");

    // Calibration results carry no events
    a_cal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.calibrating |->
            out_data.direction_event == DIR_NEUTRAL && !out_data.select_event)
        else $error("event during calibration");

    // With no result waiting, the input side never stalls
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind joystick_direction_repeat_debounce jdr_chk u_jdr_chk (.*);
